FILE: hdl/assert_macros.svh
// Assertion macros used by the assertion checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BET_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BET_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/bet_pkg.sv
package bet_pkg;

  localparam int BET_MAX_POINTS = 32;
  localparam int CNT_W = 9;

  localparam logic [15:0] MIN_STEP_RST = 16'd10;
  localparam logic [15:0] TIME_LOW_RST = 16'd0;
  localparam logic [15:0] TIME_HIGH_RST = 16'd10000;
  localparam logic [15:0] VALUE_LOW_RST = 16'd0;
  localparam logic [15:0] VALUE_HIGH_RST = 16'hFFFF;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_DISPLACE = 3'd2;
  localparam logic [2:0] CMD_QUERY = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [2:0] REG_MIN_STEP = 3'd0;
  localparam logic [2:0] REG_TIME_LOW = 3'd1;
  localparam logic [2:0] REG_TIME_HIGH = 3'd2;
  localparam logic [2:0] REG_VALUE_LOW = 3'd3;
  localparam logic [2:0] REG_VALUE_HIGH = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_init;
    logic pick;
    logic check;
    logic wr_new;
    logic step;
    logic tail;
    logic mul;
    logic div_init;
    logic div_step;
    logic finish;
  } bet_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       idx_ok;
    logic       lim_ok;
    logic       at_end;
    logic       ins_first;
    logic       has_pair;
    logic       div_done;
  } bet_stat_t;

endpackage

FILE: hdl/bet_in_if.sv
interface bet_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [15:0]        point_time;
  logic [15:0]        point_value;
  logic [7:0]         point_index;
  logic signed [16:0] delta_time;
  logic signed [16:0] delta_value;

  modport source (output valid, command, point_time, point_value, point_index,
                  delta_time, delta_value, input ready);
  modport sink (input valid, command, point_time, point_value, point_index,
                delta_time, delta_value, output ready);
endinterface

FILE: hdl/bet_out_if.sv
interface bet_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_value;
  logic        value_valid;
  logic        accepted;
  logic [8:0]  point_count;
  logic [15:0] last_time;

  modport source (output valid, result_value, value_valid, accepted, point_count,
                  last_time, input ready);
  modport sink (input valid, result_value, value_valid, accepted, point_count,
                last_time, output ready);
endinterface

FILE: hdl/bet_cfg_if.sv
interface bet_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/bet_datapath.sv
module bet_datapath
  import bet_pkg::*;
#(
  parameter int MAX_POINTS = BET_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst,
  input  bet_ctl_t           ctl,
  output bet_stat_t          st,
  input  logic [2:0]         command,
  input  logic [15:0]        point_time,
  input  logic [15:0]        point_value,
  input  logic [7:0]         point_index,
  input  logic signed [16:0] delta_time,
  input  logic signed [16:0] delta_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic [15:0]        result_value,
  output logic               value_valid,
  output logic               accepted,
  output logic [8:0]         point_count,
  output logic [15:0]        last_time
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int AW = IW + 1;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_POINTS);

  // The bank bit sits above the index bits, so the memory spans the full address range.
  logic [31:0] mem [2**AW];
  logic [31:0] rdata;

  logic [15:0] min_step, time_low, time_high, value_low, value_high;
  logic [2:0]  cmd;
  logic [15:0] t_r, v_r;
  logic [7:0]  idx_r;
  logic signed [16:0] dt_r, dv_r;

  logic             bank;
  logic [CNT_W-1:0] count, i, j;
  logic             inserted, dropped, lim_ok_r;
  logic [15:0]      nt, nv, last_w;
  logic             lo_f, up_f;
  logic [15:0]      lt, lv, ut, uv;
  logic [31:0]      p1, p2, q;
  logic [16:0]      rem;
  logic [4:0]       dcnt;

  logic [15:0] te, ve, new_t, diff, den;
  logic        drop, keep, do_wr, is_idx, acc, lim_ok, ins_first;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;
  logic signed [17:0] nt18, nv18;
  logic [16:0] rem_sh;

  assign te = rdata[31:16];
  assign ve = rdata[15:0];
  assign new_t = (cmd == CMD_DISPLACE) ? nt : t_r;
  assign diff = (te > t_r) ? (te - t_r) : (t_r - te);
  assign drop = diff < min_step;
  assign is_idx = (i == {1'b0, idx_r});
  assign den = ut - lt;

  always_comb begin
    keep = 1'b0;
    ins_first = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        keep = !drop;
        ins_first = !drop && !inserted && (te > t_r);
      end
      CMD_REMOVE: keep = !is_idx;
      CMD_DISPLACE: begin
        keep = !is_idx;
        ins_first = !is_idx && !inserted &&
                    ((te > nt) || ((te == nt) && (i > {1'b0, idx_r})));
      end
      default: keep = 1'b0;
    endcase
  end

  assign nt18 = $signed({2'b00, te}) + 18'(dt_r);
  assign nv18 = $signed({2'b00, ve}) + 18'(dv_r);
  always_comb begin
    lim_ok = 1'b1;
    if (dt_r > 0 && nt18 > $signed({2'b00, time_high})) lim_ok = 1'b0;
    if (dt_r < 0 && nt18 < $signed({2'b00, time_low})) lim_ok = 1'b0;
    if (dv_r > 0 && nv18 > $signed({2'b00, value_high})) lim_ok = 1'b0;
    if (dv_r < 0 && nv18 < $signed({2'b00, value_low})) lim_ok = 1'b0;
  end

  assign st.cmd = cmd;
  assign st.idx_ok = {1'b0, idx_r} < count;
  assign st.lim_ok = lim_ok;
  assign st.at_end = (i == count);
  assign st.ins_first = ins_first;
  assign st.has_pair = lo_f && up_f;
  assign st.div_done = (dcnt == 5'd31);

  always_comb begin
    case (cmd)
      CMD_INSERT: acc = !((count == MAXC) && !dropped);
      CMD_REMOVE: acc = st.idx_ok;
      CMD_DISPLACE: acc = st.idx_ok && lim_ok_r;
      CMD_QUERY: acc = 1'b1;
      CMD_CLEAR: acc = 1'b1;
      default: acc = 1'b0;
    endcase
  end

  // Memory ports: read from the active bank, write into the other one.
  assign raddr = {bank, i[IW-1:0]};
  assign waddr = {~bank, j[IW-1:0]};
  always_comb begin
    do_wr = 1'b0;
    wdata = rdata;
    if (j < MAXC) begin
      if (ctl.wr_new || (ctl.tail && !inserted &&
          (cmd == CMD_INSERT || cmd == CMD_DISPLACE))) begin
        do_wr = 1'b1;
        wdata = {new_t, (cmd == CMD_DISPLACE) ? nv : v_r};
      end else if (ctl.step && keep) begin
        do_wr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign rem_sh = {rem[15:0], q[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step <= MIN_STEP_RST;
      time_low <= TIME_LOW_RST;
      time_high <= TIME_HIGH_RST;
      value_low <= VALUE_LOW_RST;
      value_high <= VALUE_HIGH_RST;
      bank <= 1'b0;
      count <= '0;
      last_time <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_STEP: min_step <= cfg_data;
          REG_TIME_LOW: time_low <= cfg_data;
          REG_TIME_HIGH: time_high <= cfg_data;
          REG_VALUE_LOW: value_low <= cfg_data;
          REG_VALUE_HIGH: value_high <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.finish) begin
        if (cmd == CMD_CLEAR) begin
          count <= '0;
          last_time <= '0;
        end else if (acc && (cmd == CMD_INSERT || cmd == CMD_REMOVE ||
                             cmd == CMD_DISPLACE)) begin
          bank <= ~bank;
          count <= j;
          last_time <= (j == '0) ? 16'd0 : last_w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= command;
      t_r <= point_time;
      v_r <= point_value;
      idx_r <= point_index;
      dt_r <= delta_time;
      dv_r <= delta_value;
      lim_ok_r <= 1'b0;
    end
    if (ctl.pick) begin
      i <= {1'b0, idx_r};
    end
    if (ctl.check) begin
      nt <= nt18[15:0];
      nv <= nv18[15:0];
      lim_ok_r <= lim_ok;
    end
    if (ctl.scan_init) begin
      i <= '0;
      j <= '0;
      inserted <= 1'b0;
      dropped <= 1'b0;
      lo_f <= 1'b0;
      up_f <= 1'b0;
    end
    if (ctl.wr_new || (ctl.tail && !inserted &&
        (cmd == CMD_INSERT || cmd == CMD_DISPLACE))) begin
      inserted <= 1'b1;
      if (j < MAXC) begin
        j <= j + 1'b1;
        last_w <= new_t;
      end
    end
    if (ctl.step) begin
      i <= i + 1'b1;
      if (keep && j < MAXC) begin
        j <= j + 1'b1;
        last_w <= te;
      end
      if (cmd == CMD_INSERT && drop) dropped <= 1'b1;
      if (cmd == CMD_QUERY) begin
        if (te < t_r) begin
          lo_f <= 1'b1;
          lt <= te;
          lv <= ve;
        end
        if (!up_f && te > t_r) begin
          up_f <= 1'b1;
          ut <= te;
          uv <= ve;
        end
      end
    end
    if (ctl.mul) begin
      p1 <= 32'(lv) * 32'(ut - t_r);
      p2 <= 32'(uv) * 32'(t_r - lt);
    end
    if (ctl.div_init) begin
      q <= p1 + p2 + {17'd0, den[15:1]};
      rem <= '0;
      dcnt <= '0;
    end
    if (ctl.div_step) begin
      dcnt <= dcnt + 1'b1;
      if (rem_sh >= {1'b0, den}) begin
        rem <= rem_sh - {1'b0, den};
        q <= {q[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q <= {q[30:0], 1'b0};
      end
    end
    if (ctl.finish) begin
      value_valid <= (cmd == CMD_QUERY) && lo_f && up_f;
      result_value <= ((cmd == CMD_QUERY) && lo_f && up_f) ? q[15:0] : 16'd0;
      accepted <= acc;
    end
  end

  assign point_count = count;

endmodule

FILE: hdl/bet_ctrl.sv
module bet_ctrl
  import bet_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bet_stat_t st,
  output bet_ctl_t  ctl
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_START  = 10'b0000000010,
    S_PICK_F = 10'b0000000100,
    S_PICK_E = 10'b0000001000,
    S_FETCH  = 10'b0000010000,
    S_EVAL   = 10'b0000100000,
    S_MUL    = 10'b0001000000,
    S_DINIT  = 10'b0010000000,
    S_DIV    = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        case (st.cmd)
          CMD_INSERT, CMD_QUERY: begin
            ctl.scan_init = 1'b1;
            state_next = S_FETCH;
          end
          CMD_REMOVE: begin
            ctl.scan_init = st.idx_ok;
            state_next = st.idx_ok ? S_FETCH : S_FINISH;
          end
          CMD_DISPLACE: begin
            ctl.pick = st.idx_ok;
            state_next = st.idx_ok ? S_PICK_F : S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_PICK_F: state_next = S_PICK_E;
      S_PICK_E: begin
        ctl.check = 1'b1;
        ctl.scan_init = st.lim_ok;
        state_next = st.lim_ok ? S_FETCH : S_FINISH;
      end
      S_FETCH: begin
        if (st.at_end) begin
          ctl.tail = 1'b1;
          state_next = (st.cmd == CMD_QUERY && st.has_pair) ? S_MUL : S_FINISH;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.ins_first) begin
          ctl.wr_new = 1'b1;
        end else begin
          ctl.step = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_MUL: begin
        ctl.mul = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        ctl.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (st.div_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/breakpoint_envelope_table_top.sv
// Breakpoint envelope table. The block holds up to MAX_POINTS breakpoints
// (time in ms, value in unsigned Q0.16) sorted by time, and runs one command
// per input word: insert (after dropping points closer than min_time_step),
// remove by index, displace within the configured limits, query the linearly
// interpolated value rounded half up, or clear. Each command yields exactly
// one result word. The table lives in a memory of two banks; every accepted
// editing command streams the active bank into the other one, skipping or
// adding points on the way, and then swaps banks. A scan fetches and evaluates
// each stored point in turn, with one more evaluation step when the new point
// is written in mid-table, and a query with points on both sides then forms
// the product and runs a bit-serial 32-step division. Clear and refused
// commands that need no scan finish without one. A new input word is taken
// in the cycle after the previous one has finished, even while its result
// word still waits in the output register. Configuration writes are taken at
// any time but should only be issued while the block is idle. No clearing
// pass is needed after reset.
module breakpoint_envelope_table_top
  import bet_pkg::*;
#(
  parameter int MAX_POINTS = BET_MAX_POINTS
) (
  input logic clk,
  input logic rst,
  bet_in_if.sink    req,
  bet_out_if.source rsp,
  bet_cfg_if.sink   cfg
);

  bet_ctl_t  ctl;
  bet_stat_t st;

  // Configuration is always accepted.
  assign cfg.ready = 1'b1;

  bet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .ctl       (ctl)
  );

  bet_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .command      (req.command),
    .point_time   (req.point_time),
    .point_value  (req.point_value),
    .point_index  (req.point_index),
    .delta_time   (req.delta_time),
    .delta_value  (req.delta_value),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .result_value (rsp.result_value),
    .value_valid  (rsp.value_valid),
    .accepted     (rsp.accepted),
    .point_count  (rsp.point_count),
    .last_time    (rsp.last_time)
  );

endmodule

FILE: hdl/bet_checker.sv
`include "assert_macros.svh"

module bet_assert_checker
  import bet_pkg::*;
#(
  parameter int MAX_POINTS = BET_MAX_POINTS
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result_value,
  input logic        value_valid,
  input logic        accepted,
  input logic [8:0]  point_count
);

  `BET_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_value))
  `BET_ASSERT_IMP(a_count_max, clk, rst, out_valid, point_count <= 9'(MAX_POINTS))
  `BET_ASSERT_IMP(a_zero_invalid, clk, rst, out_valid && !value_valid, result_value == 16'd0)
  `BET_ASSERT_IMP(a_valid_acc, clk, rst, out_valid && value_valid, accepted)

endmodule

bind breakpoint_envelope_table_top bet_assert_checker #(.MAX_POINTS(MAX_POINTS)) u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .result_value (rsp.result_value),
  .value_valid  (rsp.value_valid),
  .accepted     (rsp.accepted),
  .point_count  (rsp.point_count)
);

FILE: tb/bet_checker.sv
`timescale 1ns / 1ps
module bet_checker
  import bet_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bet_in_if.sink    req_mon,
  bet_out_if.sink   rsp_mon,
  bet_cfg_if.sink   cfg_mon,
  output int        fail_count,
  output int        pending_count,
  output logic      activity
);

  typedef struct packed {
    logic [15:0] result_value;
    logic        value_valid;
    logic        accepted;
    logic [8:0]  point_count;
    logic [15:0] last_time;
  } envelope_result_t;

  logic [15:0] min_step, t_low, t_high, v_low, v_high;
  logic [15:0] times[BET_MAX_POINTS];
  logic [15:0] values[BET_MAX_POINTS];
  int          npoints;
  envelope_result_t expected_results[$];

  function automatic void drop_point(int idx);
    for (int i = idx; i + 1 < npoints; i++) begin
      times[i] = times[i + 1];
      values[i] = values[i + 1];
    end
    npoints--;
  endfunction

  function automatic bit add_point(logic [15:0] t, logic [15:0] v);
    int i;
    int pos;
    int d;
    i = 0;
    while (i < npoints) begin
      d = (times[i] > t) ? int'(times[i]) - int'(t) : int'(t) - int'(times[i]);
      if (d < int'(min_step)) drop_point(i);
      else i++;
    end
    if (npoints >= BET_MAX_POINTS) return 0;
    pos = 0;
    while (pos < npoints && times[pos] <= t) pos++;
    for (i = npoints; i > pos; i--) begin
      times[i] = times[i - 1];
      values[i] = values[i - 1];
    end
    times[pos] = t;
    values[pos] = v;
    npoints++;
    return 1;
  endfunction

  function automatic bit move_point(int idx, logic signed [16:0] dt,
                                    logic signed [16:0] dv);
    longint nt;
    longint nv;
    logic [15:0] kt;
    logic [15:0] kv;
    int j;
    if (idx >= npoints) return 0;
    nt = longint'(times[idx]) + longint'(dt);
    nv = longint'(values[idx]) + longint'(dv);
    if (dt > 0 && nt > longint'(t_high)) return 0;
    if (dt < 0 && nt < longint'(t_low)) return 0;
    if (dv > 0 && nv > longint'(v_high)) return 0;
    if (dv < 0 && nv < longint'(v_low)) return 0;
    times[idx] = nt[15:0];
    values[idx] = nv[15:0];
    // Insertion sort keeps equal times in their previous order.
    for (int i = 1; i < npoints; i++) begin
      kt = times[i];
      kv = values[i];
      j = i;
      while (j > 0 && times[j - 1] > kt) begin
        times[j] = times[j - 1];
        values[j] = values[j - 1];
        j--;
      end
      times[j] = kt;
      values[j] = kv;
    end
    return 1;
  endfunction

  function automatic bit interpolate(logic [15:0] t, output logic [15:0] res);
    int lo;
    int up;
    bit has_lo;
    bit has_up;
    longint den;
    longint x;
    longint num;
    lo = 0;
    up = 0;
    has_lo = 0;
    has_up = 0;
    res = '0;
    for (int i = 0; i < npoints; i++) begin
      if (times[i] < t) begin
        lo = i;
        has_lo = 1;
      end
      if (!has_up && times[i] > t) begin
        up = i;
        has_up = 1;
      end
    end
    if (!has_lo || !has_up) return 0;
    den = longint'(times[up]) - longint'(times[lo]);
    x = longint'(t) - longint'(times[lo]);
    num = longint'(values[lo]) * (den - x) + longint'(values[up]) * x;
    res = 16'((num + den / 2) / den);
    return 1;
  endfunction

  function automatic envelope_result_t run_command();
    envelope_result_t r;
    logic [15:0] q;
    r = '0;
    case (req_mon.command)
      CMD_INSERT: r.accepted = add_point(req_mon.point_time, req_mon.point_value);
      CMD_REMOVE: begin
        if (int'(req_mon.point_index) < npoints) begin
          drop_point(int'(req_mon.point_index));
          r.accepted = 1;
        end
      end
      CMD_DISPLACE: r.accepted = move_point(int'(req_mon.point_index),
                                            req_mon.delta_time, req_mon.delta_value);
      CMD_QUERY: begin
        r.value_valid = interpolate(req_mon.point_time, q);
        r.result_value = r.value_valid ? q : 16'd0;
        r.accepted = 1;
      end
      CMD_CLEAR: begin
        npoints = 0;
        r.accepted = 1;
      end
      default: r.accepted = 0;
    endcase
    r.point_count = 9'(npoints);
    r.last_time = (npoints > 0) ? times[npoints - 1] : 16'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    envelope_result_t got;
    envelope_result_t want;
    logic moved;
    moved = 1'b0;
    if (rst) begin
      min_step <= MIN_STEP_RST;
      t_low <= TIME_LOW_RST;
      t_high <= TIME_HIGH_RST;
      v_low <= VALUE_LOW_RST;
      v_high <= VALUE_HIGH_RST;
      npoints = 0;
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        moved = 1'b1;
        case (cfg_mon.index)
          REG_MIN_STEP: min_step <= cfg_mon.data;
          REG_TIME_LOW: t_low <= cfg_mon.data;
          REG_TIME_HIGH: t_high <= cfg_mon.data;
          REG_VALUE_LOW: v_low <= cfg_mon.data;
          REG_VALUE_HIGH: v_high <= cfg_mon.data;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        moved = 1'b1;
        expected_results.insert(expected_results.size(), run_command());
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        moved = 1'b1;
        got = '{rsp_mon.result_value, rsp_mon.value_valid, rsp_mon.accepted,
                rsp_mon.point_count, rsp_mon.last_time};
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("Mismatch: expected %p, got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_results.size();
    end
    activity <= moved;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import bet_pkg::*;

  // The limit is generous next to the longest commands, edits of a full table
  // and queries with a division.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_WORDS = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  logic activity;
  int   quiet_cycles;
  bit   no_idle;

  bet_in_if  req();
  bet_out_if rsp();
  bet_cfg_if cfg();

  breakpoint_envelope_table_top uut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg)
  );

  bet_checker checker_i (
    .clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp), .cfg_mon(cfg),
    .fail_count(fail_count), .pending_count(pending_count), .activity(activity)
  );

  always #1 clk = ~clk;

  // The watchdog ends the run if no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || activity) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // The result side stalls at random, except in the phase without idling.
  always @(negedge clk) begin
    rsp.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
  end

  // Sends one word and returns at the falling edge after it has been taken.
  // Valid stays high until the next word or an idle cycle replaces it.
  task automatic send_word(logic [2:0] c, logic [15:0] t, logic [15:0] v,
                           logic [7:0] idx, logic signed [16:0] dt,
                           logic signed [16:0] dv);
    while (!no_idle && $urandom_range(99) < 12) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.command <= c;
    req.point_time <= t;
    req.point_value <= v;
    req.point_index <= idx;
    req.delta_time <= dt;
    req.delta_value <= dv;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // Waits until every result has arrived plus a settling margin.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
  endtask

  task automatic set_limits(logic [15:0] ms, logic [15:0] tl, logic [15:0] th,
                            logic [15:0] vl, logic [15:0] vh);
    drain();
    write_reg(REG_MIN_STEP, ms);
    write_reg(REG_TIME_LOW, tl);
    write_reg(REG_TIME_HIGH, th);
    write_reg(REG_VALUE_LOW, vl);
    write_reg(REG_VALUE_HIGH, vh);
    cfg.valid <= 1'b0;
  endtask

  // Random word: mostly inserts and queries so that the table fills up,
  // with times drawn from a narrow span on most words to make neighbours.
  task automatic random_word(int span);
    logic [2:0]         c;
    int                 pick;
    logic [15:0]        t;
    logic signed [16:0] dt;
    logic signed [16:0] dv;
    pick = $urandom_range(99);
    if (pick < 40) c = CMD_INSERT;
    else if (pick < 50) c = CMD_REMOVE;
    else if (pick < 65) c = CMD_DISPLACE;
    else if (pick < 97) c = CMD_QUERY;
    else if (pick < 98) c = CMD_CLEAR;
    else c = 3'($urandom_range(7, 5));
    t = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(span));
    dt = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($signed($urandom_range(400)) - 200);
    dv = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($signed($urandom_range(8000)) - 4000);
    if ($urandom_range(7) == 0) dt = '0;
    if ($urandom_range(7) == 0) dv = '0;
    send_word(c, t, 16'($urandom),
              ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(35)),
              dt, dv);
  endtask

  initial begin
    req.valid = 1'b0;
    req.command = CMD_QUERY;
    req.point_time = '0;
    req.point_value = '0;
    req.point_index = '0;
    req.delta_time = '0;
    req.delta_value = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_MIN_STEP;
    cfg.data = '0;
    rsp.ready = 1'b0;
    no_idle = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with reset settings: a query on an empty table, an insert
    // into an empty table, points on one side only, equal times, and a drop.
    send_word(CMD_QUERY, 16'd100, 16'd0, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_REMOVE, 16'd0, 16'd0, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_INSERT, 16'd0, 16'hFFFF, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_QUERY, 16'd0, 16'd0, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_INSERT, 16'd1000, 16'd0, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_QUERY, 16'd333, 16'd0, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_QUERY, 16'd1000, 16'd0, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_INSERT, 16'd1005, 16'd1234, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_INSERT, 16'hFFFF, 16'd7, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_DISPLACE, 16'd0, 16'd0, 8'd0, 17'sd65535, 17'sd0);
    send_word(CMD_DISPLACE, 16'd0, 16'd0, 8'd1, 17'sd500, -17'sd65535);
    send_word(CMD_DISPLACE, 16'd0, 16'd0, 8'd0, -17'sd65535, 17'sd1);
    send_word(CMD_DISPLACE, 16'd0, 16'd0, 8'd200, 17'sd0, 17'sd0);
    send_word(CMD_REMOVE, 16'd0, 16'd0, 8'd255, 17'sd0, 17'sd0);
    send_word(CMD_QUERY, 16'd1200, 16'd0, 8'd0, 17'sd0, 17'sd0);
    send_word(3'd7, 16'd5, 16'd5, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_CLEAR, 16'd0, 16'd0, 8'd0, 17'sd0, 17'sd0);

    // Zero spacing lets points share a time; a huge spacing empties the table
    // on every insert.
    set_limits(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    send_word(CMD_INSERT, 16'd50, 16'd10, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_INSERT, 16'd50, 16'd20, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_INSERT, 16'd60, 16'd30, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_QUERY, 16'd55, 16'd0, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_DISPLACE, 16'd0, 16'd0, 8'd0, 17'sd20, 17'sd0);
    set_limits(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    send_word(CMD_INSERT, 16'd70, 16'd1, 8'd0, 17'sd0, 17'sd0);
    send_word(CMD_DISPLACE, 16'd0, 16'd0, 8'd0, 17'sd1, -17'sd1);

    // Random phases under several settings, one of them without any idling.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_limits(16'd10, 16'd0, 16'd10000, 16'd0, 16'hFFFF);
        1: set_limits(16'd0, 16'd100, 16'd2000, 16'd1000, 16'd60000);
        2: set_limits(16'd3, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        default: set_limits(16'($urandom_range(40)), 16'($urandom_range(500)),
                            16'($urandom_range(65535, 1000)), 16'($urandom_range(3000)),
                            16'($urandom_range(65535, 30000)));
      endcase
      no_idle = (phase == 2);
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        random_word((phase == 1) ? 2000 : 600);
        // Let the block run dry once per phase before the next word.
        if (n == 75) begin
          req.valid <= 1'b0;
          while (pending_count != 0) @(negedge clk);
        end
      end
    end
    no_idle = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
